// ===== src/ppa_pkg.sv =====
`timescale 1ns / 1ps

package ppa_pkg;

  localparam int PAGE_COUNT_DEF = 4096;
  localparam int NUM_PROCS_DEF  = 256;

  localparam int KIND_W      = 2;
  localparam int PID_W       = 9;
  localparam int INDEX_W     = 13;
  localparam int STATUS_W    = 3;
  localparam int PAGE_OUT_W  = 12;
  localparam int COUNT_OUT_W = 13;
  localparam int RSV_W       = 13;
  localparam int OWNER_W     = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_BAD_PID      = 3'd2,
    ST_BAD_INDEX    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_t;

  // one page table entry
  typedef struct packed {
    logic               in_use;
    logic [OWNER_W-1:0] owner;
  } ppa_entry_t;

  // free queue command
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ppa_qcmd_t;

endpackage

// ===== src/ppa_req_if.sv =====
`timescale 1ns / 1ps

interface ppa_req_if;
  import ppa_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [PID_W-1:0]   pid;
  logic [INDEX_W-1:0] page_index;

  modport source (output valid, kind, pid, page_index, input ready);
  modport sink (input valid, kind, pid, page_index, output ready);
endinterface

// ===== src/ppa_resp_if.sv =====
`timescale 1ns / 1ps

interface ppa_resp_if;
  import ppa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [PAGE_OUT_W-1:0]  alloc_page;
  logic [COUNT_OUT_W-1:0] free_count;

  modport source (output valid, status, alloc_page, free_count, input ready);
  modport sink (input valid, status, alloc_page, free_count, output ready);
endinterface

// ===== src/physical_page_allocator.sv =====
// Physical page allocator: a FIFO free list of page numbers plus a page table of in-use
// bits and owner ids, both in single-port-write synchronous memories. Allocate, free and
// unknown-kind items are accepted, then done as one read-modify-write of the queue head
// and the page table entry, held while the output register is full; the result then
// sits in an output register while the next item is taken. An init item sweeps the page
// table one entry per cycle, then finishes like the others. After reset the block clears
// the page table in one pass during which it takes no item; reserved_pages may be written
// anytime the block is idle.
`timescale 1ns / 1ps

module physical_page_allocator #(
  parameter int PAGE_COUNT = ppa_pkg::PAGE_COUNT_DEF,
  parameter int NUM_PROCS  = ppa_pkg::NUM_PROCS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ppa_pkg::RSV_W-1:0] cfg_wdata,
  ppa_req_if.sink                   req,
  ppa_resp_if.source                rsp
);
  import ppa_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int CNT_W  = $clog2(PAGE_COUNT + 1);
  localparam int CMP_W  = (PAGE_W > INDEX_W) ? PAGE_W + 1 : INDEX_W + 1;
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [CNT_W-1:0]  FULL      = CNT_W'(PAGE_COUNT);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t             state;
  logic [RSV_W-1:0]   reserved;
  logic [PAGE_W-1:0]  sweep_page;
  kind_t              kind_q;
  logic [PID_W-1:0]   pid_q;
  logic [INDEX_W-1:0] idx_q;

  logic                   rsp_valid;
  status_t                rsp_status;
  logic [PAGE_OUT_W-1:0]  rsp_page;
  logic [COUNT_OUT_W-1:0] rsp_count;

  ppa_qcmd_t         qcmd;
  logic [PAGE_W-1:0] q_push_page;
  logic [PAGE_W-1:0] q_head_page;
  logic [CNT_W-1:0]  q_count;

  logic [PAGE_W-1:0] t_rd_addr;
  ppa_entry_t        t_rd_data;
  logic              t_we;
  logic [PAGE_W-1:0] t_wr_addr;
  ppa_entry_t        t_wr_data;

  logic              accept;
  logic              out_free;
  logic              go;
  logic              idx_ok;
  logic              pid_ok;
  logic              sweep_reserved;
  logic [PAGE_W-1:0] idx_page;
  status_t           status_next;
  logic [PAGE_W-1:0] page_next;
  logic [CNT_W-1:0]  count_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign go        = (state == S_EXEC) && out_free;

  assign idx_page       = PAGE_W'(idx_q);
  assign idx_ok         = CMP_W'(idx_q) < CMP_W'(PAGE_COUNT);
  assign pid_ok         = pid_q < PID_W'(NUM_PROCS);
  assign sweep_reserved = CMP_W'(sweep_page) < CMP_W'(reserved);

  // page table is read at the accept edge, re-read from the held index while stalled
  assign t_rd_addr = (state == S_IDLE) ? PAGE_W'(req.page_index) : idx_page;

  always_comb begin
    qcmd        = '0;
    q_push_page = idx_page;
    t_we        = 1'b0;
    t_wr_addr   = idx_page;
    t_wr_data   = '0;
    status_next = ST_OK;
    page_next   = '0;
    count_next  = q_count;
    qcmd.clear  = accept && (req.kind == KIND_INIT);
    unique case (state)
      S_CLEAR: begin
        t_we      = 1'b1;
        t_wr_addr = sweep_page;
      end
      S_SWEEP: begin
        t_we             = 1'b1;
        t_wr_addr        = sweep_page;
        t_wr_data.in_use = sweep_reserved;
        qcmd.push        = !sweep_reserved;
        q_push_page      = sweep_page;
      end
      S_EXEC: begin
        unique case (kind_q)
          KIND_ALLOC: begin
            if (q_count == '0) begin
              status_next = ST_EMPTY;
            end else if (!pid_ok) begin
              status_next = ST_BAD_PID;
            end else begin
              qcmd.pop         = go;
              t_we             = go;
              t_wr_addr        = q_head_page;
              t_wr_data.in_use = 1'b1;
              t_wr_data.owner  = pid_q[OWNER_W-1:0];
              page_next        = q_head_page;
              count_next       = q_count - 1'b1;
            end
          end
          KIND_FREE: begin
            if (!idx_ok) begin
              status_next = ST_BAD_INDEX;
            end else if (!t_rd_data.in_use || q_count == FULL) begin
              status_next = ST_ALREADY_FREE;
            end else begin
              qcmd.push  = go;
              t_we       = go;
              count_next = q_count + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep_page <= '0;
      reserved   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        reserved <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          sweep_page <= sweep_page + 1'b1;
          if (sweep_page == LAST_PAGE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            sweep_page <= '0;
            state      <= (req.kind == KIND_INIT) ? S_SWEEP : S_EXEC;
          end
        end
        S_SWEEP: begin
          sweep_page <= sweep_page + 1'b1;
          if (sweep_page == LAST_PAGE) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_t'(req.kind);
      pid_q  <= req.pid;
      idx_q  <= req.page_index;
    end
    if (go) begin
      rsp_status <= status_next;
      rsp_page   <= PAGE_OUT_W'(page_next);
      rsp_count  <= COUNT_OUT_W'(count_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.alloc_page = rsp_page;
  assign rsp.free_count = rsp_count;

  ppa_free_queue #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (qcmd),
    .push_page (q_push_page),
    .head_page (q_head_page),
    .count     (q_count)
  );

  ppa_page_table #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_table (
    .clk     (clk),
    .rd_addr (t_rd_addr),
    .rd_data (t_rd_data),
    .we      (t_we),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data)
  );

  a_page_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.alloc_page == '0)
    else $error("page reported on a failed item");
  a_pop_alloc: assert property (@(posedge clk) disable iff (rst)
    qcmd.pop |-> state == S_EXEC && kind_q == KIND_ALLOC && t_wr_data.in_use)
    else $error("queue pop outside a successful allocate");
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SWEEP || state == S_EXEC)
    else $error("accepted item not started");
  a_exec_write: assert property (@(posedge clk) disable iff (rst)
    t_we && state == S_EXEC |-> t_wr_data.in_use == (kind_q == KIND_ALLOC))
    else $error("page table write does not match the item");
endmodule

// ===== src/ppa_free_queue.sv =====
`timescale 1ns / 1ps

module ppa_free_queue #(
  parameter int PAGE_COUNT = ppa_pkg::PAGE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppa_pkg::ppa_qcmd_t                cmd,
  input  logic [$clog2(PAGE_COUNT)-1:0]     push_page,
  output logic [$clog2(PAGE_COUNT)-1:0]     head_page,
  output logic [$clog2(PAGE_COUNT+1)-1:0]   count
);
  import ppa_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int CNT_W  = $clog2(PAGE_COUNT + 1);
  localparam logic [PAGE_W-1:0] LAST_SLOT = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [CNT_W-1:0]  FULL      = CNT_W'(PAGE_COUNT);

  logic [PAGE_W-1:0] mem [PAGE_COUNT];
  logic [PAGE_W-1:0] head;
  logic [PAGE_W-1:0] tail;

  // head entry is re-read every cycle, so it is current in the cycle after head moves
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_page;
    end
    head_page <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
      end
      if (cmd.pop) begin
        head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("free queue count above page count");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) cmd.pop |-> count != '0)
    else $error("pop from empty free queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) cmd.push |-> count != FULL)
    else $error("push to full free queue");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop) && !(cmd.clear && (cmd.push || cmd.pop)))
    else $error("conflicting free queue commands");
endmodule

// ===== src/ppa_page_table.sv =====
`timescale 1ns / 1ps

module ppa_page_table #(
  parameter int PAGE_COUNT = ppa_pkg::PAGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_addr,
  output ppa_pkg::ppa_entry_t           rd_data,
  input  logic                          we,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_addr,
  input  ppa_pkg::ppa_entry_t           wr_data
);
  import ppa_pkg::*;

  ppa_entry_t mem [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== test/ppa_checker.sv =====
`timescale 1ns / 1ps

module ppa_checker
  import ppa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int NUM_PROCS  = NUM_PROCS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RSV_W-1:0] cfg_wdata,
  ppa_req_if               req,
  ppa_resp_if              rsp,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    status_t                status;
    logic [PAGE_OUT_W-1:0]  page;
    logic [COUNT_OUT_W-1:0] count;
  } page_result_t;

  // shadow copy of the allocator state
  logic [PAGE_OUT_W-1:0] free_ring [PAGE_COUNT];
  logic                  page_busy [PAGE_COUNT];
  logic [OWNER_W-1:0]    page_pid  [PAGE_COUNT];
  int                    ring_head;
  int                    ring_tail;
  int                    ring_count;
  int                    rsv_pages;

  page_result_t owed_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic rebuild_tables();
    int keep;
    keep = (rsv_pages > PAGE_COUNT) ? PAGE_COUNT : rsv_pages;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    for (int p = 0; p < PAGE_COUNT; p++) begin
      page_pid[p] = '0;
      if (p < keep) begin
        page_busy[p] = 1'b1;
      end else begin
        page_busy[p] = 1'b0;
        free_ring[ring_tail] = p[PAGE_OUT_W-1:0];
        ring_tail = (ring_tail + 1) % PAGE_COUNT;
        ring_count++;
      end
    end
  endtask

  task automatic predict_page_op(input kind_t k, input logic [PID_W-1:0] pid,
                                 input logic [INDEX_W-1:0] idx);
    page_result_t r;
    int pg;
    r.status = ST_OK;
    r.page   = '0;
    case (k)
      KIND_INIT: begin
        rebuild_tables();
      end
      KIND_ALLOC: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pid) >= NUM_PROCS) begin
          r.status = ST_BAD_PID;
        end else begin
          pg = int'(free_ring[ring_head]) % PAGE_COUNT;
          ring_head = (ring_head + 1) % PAGE_COUNT;
          ring_count--;
          page_busy[pg] = 1'b1;
          page_pid[pg]  = pid[OWNER_W-1:0];
          r.page = pg[PAGE_OUT_W-1:0];
        end
      end
      KIND_FREE: begin
        if (int'(idx) >= PAGE_COUNT) begin
          r.status = ST_BAD_INDEX;
        end else if (!page_busy[idx] || ring_count >= PAGE_COUNT) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          page_busy[idx] = 1'b0;
          page_pid[idx]  = '0;
          free_ring[ring_tail] = idx[PAGE_OUT_W-1:0];
          ring_tail = (ring_tail + 1) % PAGE_COUNT;
          ring_count++;
        end
      end
      default: ;
    endcase
    r.count = ring_count[COUNT_OUT_W-1:0];
    owed_results.push_back(r);
  endtask

  always @(posedge clk) begin
    page_result_t want;
    if (rst) begin
      rsv_pages  = 0;
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      for (int p = 0; p < PAGE_COUNT; p++) begin
        page_busy[p] = 1'b0;
        page_pid[p]  = '0;
      end
      owed_results.delete();
    end else begin
      if (cfg_we) rsv_pages = int'(cfg_wdata);
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          flag_error($sformatf("result with no item outstanding: status=%0d page=%0d count=%0d",
                               rsp.status, rsp.alloc_page, rsp.free_count));
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status)
            flag_error($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.alloc_page !== want.page)
            flag_error($sformatf("alloc_page got %0d want %0d", rsp.alloc_page, want.page));
          if (rsp.free_count !== want.count)
            flag_error($sformatf("free_count got %0d want %0d", rsp.free_count, want.count));
        end
      end
      if (req.valid && req.ready)
        predict_page_op(kind_t'(req.kind), req.pid, req.page_index);
    end
    pending = owed_results.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ppa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [RSV_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_start;
  logic hold_off;
  int idle_cycles;

  ppa_req_if  req_ch ();
  ppa_resp_if rsp_ch ();

  physical_page_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch.sink),
    .rsp       (rsp_ch.source)
  );

  ppa_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // response side: random stalls plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (hold_start === 1'b1);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer_item(input kind_t k, input logic [PID_W-1:0] pid,
                            input logic [INDEX_W-1:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= k;
    req_ch.pid        <= pid;
    req_ch.page_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reserved(input logic [RSV_W-1:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_page_op();
    int pick;
    kind_t k;
    logic [PID_W-1:0] pid;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    pid  = PID_W'($urandom_range(0, 511));
    idx  = INDEX_W'($urandom_range(0, 8191));
    if (pick < 1) begin
      k = KIND_INIT;
    end else if (pick < 47) begin
      k = KIND_ALLOC;
      if ($urandom_range(0, 99) < 88) pid = PID_W'($urandom_range(0, NUM_PROCS_DEF - 1));
    end else if (pick < 93) begin
      k = KIND_FREE;
      pick = $urandom_range(0, 99);
      // mostly the pages near the top that circulate through the free list
      if (pick < 75) begin
        idx = INDEX_W'($urandom_range(PAGE_COUNT_DEF - 128, PAGE_COUNT_DEF - 1));
      end else if (pick < 85) begin
        idx = INDEX_W'($urandom_range(0, PAGE_COUNT_DEF - 1));
      end
    end else begin
      k = KIND_NOP;
    end
    offer_item(k, pid, idx);
  endtask

  int idle_tab  [5] = '{0, 81, 0, 24, 40};
  int stall_tab [5] = '{0, 0, 81, 24, 40};
  int rsv_tab   [5] = '{4064, 4090, 4032, 4096, 3980};

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_NOP;
    req_ch.pid        = '0;
    req_ch.page_index = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_start        = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // before any init every page reads as free and the list is empty
    offer_item(KIND_FREE, 9'd0, 13'd5);
    offer_item(KIND_ALLOC, 9'd3, 13'd0);
    offer_item(KIND_ALLOC, 9'd511, 13'd8191);
    offer_item(KIND_NOP, 9'd511, 13'd8191);
    offer_item(KIND_FREE, 9'd0, 13'd8191);

    write_reserved(13'd4093);
    offer_item(KIND_INIT, 9'd0, 13'd0);
    offer_item(KIND_ALLOC, 9'd300, 13'd0);
    offer_item(KIND_ALLOC, 9'd0, 13'd0);
    offer_item(KIND_ALLOC, 9'd255, 13'd0);
    offer_item(KIND_ALLOC, 9'd170, 13'd0);
    offer_item(KIND_ALLOC, 9'd256, 13'd0);
    offer_item(KIND_FREE, 9'd0, 13'd4094);
    offer_item(KIND_FREE, 9'd0, 13'd4094);
    offer_item(KIND_FREE, 9'd0, 13'd4096);
    // reserved pages may be freed like any other
    offer_item(KIND_FREE, 9'd0, 13'd0);
    offer_item(KIND_ALLOC, 9'd85, 13'd0);
    offer_item(KIND_ALLOC, 9'd1, 13'd0);

    // reserved count beyond the page count queues nothing
    write_reserved(13'd8191);
    offer_item(KIND_INIT, 9'd0, 13'd0);
    offer_item(KIND_ALLOC, 9'd7, 13'd0);
    offer_item(KIND_FREE, 9'd0, 13'd4095);
    offer_item(KIND_ALLOC, 9'd85, 13'd0);

    write_reserved(13'd0);
    offer_item(KIND_INIT, 9'd0, 13'd0);
    offer_item(KIND_FREE, 9'd0, 13'd100);
    offer_item(KIND_ALLOC, 9'd2, 13'd0);

    for (int ph = 0; ph < 5; ph++) begin
      write_reserved(RSV_W'(rsv_tab[ph]));
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct <= stall_tab[ph];
      offer_item(KIND_INIT, PID_W'($urandom_range(0, 511)),
                 INDEX_W'($urandom_range(0, 8191)));
      if (ph == 0) hold_start <= 1'b1;
      for (int i = 0; i < 375; i++) begin
        if (ph == 2 && i == 180) wait_drained();
        random_page_op();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
